[rtl/plik_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plik_pkg
// Types, widths, angle constants and codes shared by the three-link
// inverse kinematics solver.
// ----------------------------------------------------------------------------
package plik_pkg;

    localparam int JOINTS = 3;

    localparam int ZW   = 30;
    localparam int XW   = 33;
    localparam int CW   = 18;
    localparam int SSW  = 19;
    localparam int LW   = 35;
    localparam int EW   = 22;
    localparam int ESW  = 46;
    localparam int JW   = 21;
    localparam int AW   = 44;
    localparam int GW   = 25;
    localparam int PW   = 50;
    localparam int DW   = 51;
    localparam int WPW  = 47;
    localparam int WW   = 48;
    localparam int NW   = 64;
    localparam int DSW  = PW + 32;
    localparam int QW   = 32;
    localparam int UW   = 33;
    localparam int SPW  = 54;
    localparam int SJW  = 40;
    localparam int GPW  = 57;
    localparam int QSW  = 39;

    localparam logic signed [ZW-1:0] ANG_PI       = 30'sd52707179;
    localparam logic signed [ZW-1:0] NEG_PI       = -30'sd52707179;
    localparam logic signed [ZW-1:0] ANG_HALF_PI  = 30'sd26353589;
    localparam logic signed [ZW-1:0] NEG_HALF_PI  = -30'sd26353589;
    localparam logic signed [ZW-1:0] ANG_TWO_PI   = 30'sd105414357;
    localparam logic signed [XW-1:0] CORDIC_START = 33'sd652032874;

    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_LIMIT     = 2'd1;
    localparam logic [1:0] ST_SINGULAR  = 2'd2;

    localparam logic [7:0] REG_STEP_GAIN       = 8'd0;
    localparam logic [7:0] REG_ERROR_TOLERANCE = 8'd1;
    localparam logic [7:0] REG_ITERATION_LIMIT = 8'd2;
    localparam logic [7:0] REG_LINK_LENGTH     = 8'd3;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_ACC, OP_ZLOAD, OP_WRAP, OP_FOLD, OP_ROT, OP_SC,
        OP_SUMS, OP_ERR, OP_ESQ, OP_JAC, OP_GRAM, OP_ABC, OP_DET, OP_DET2,
        OP_W, OP_W2, OP_DIVI, OP_DIVS, OP_DIVE, OP_ST1, OP_ST2, OP_ST3, OP_ST4,
        OP_PUB
    } plik_op_t;

    typedef struct packed {
        plik_op_t   op;
        logic [1:0] joint;
        logic [4:0] step;
        logic       sel;
        logic       first;
        logic [1:0] code;
        logic [9:0] iters;
    } plik_cmd_t;

    typedef struct packed {
        logic z_wide;
        logic converged;
        logic singular;
    } plik_status_t;

    typedef struct packed {
        logic [15:0] step_gain;
        logic [12:0] error_tolerance;
        logic [9:0]  iteration_limit;
        logic [13:0] link_length;
    } plik_cfg_t;

    typedef struct packed {
        logic signed [15:0] start_angle_0;
        logic signed [15:0] start_angle_1;
        logic signed [15:0] start_angle_2;
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
    } plik_in_t;

    typedef struct packed {
        logic signed [15:0] joint_angle_0;
        logic signed [15:0] joint_angle_1;
        logic signed [15:0] joint_angle_2;
        logic [1:0]         solve_status;
        logic [9:0]         iterations_used;
    } plik_out_t;

    function automatic logic [23:0] atan_lookup(input logic [4:0] idx);
        logic [23:0] r;
        case (idx)
            5'd0:    r = 24'd13176795;
            5'd1:    r = 24'd7778716;
            5'd2:    r = 24'd4110060;
            5'd3:    r = 24'd2086331;
            5'd4:    r = 24'd1047214;
            5'd5:    r = 24'd524117;
            5'd6:    r = 24'd262123;
            5'd7:    r = 24'd131069;
            5'd8:    r = 24'd65536;
            5'd9:    r = 24'd32768;
            5'd10:   r = 24'd16384;
            5'd11:   r = 24'd8192;
            5'd12:   r = 24'd4096;
            5'd13:   r = 24'd2048;
            5'd14:   r = 24'd1024;
            5'd15:   r = 24'd512;
            5'd16:   r = 24'd256;
            5'd17:   r = 24'd128;
            5'd18:   r = 24'd64;
            5'd19:   r = 24'd32;
            5'd20:   r = 24'd16;
            5'd21:   r = 24'd8;
            5'd22:   r = 24'd4;
            5'd23:   r = 24'd2;
            default: r = 24'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/plik_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plik_if
// Valid/ready stream interfaces for the request and result channels.
// ----------------------------------------------------------------------------
interface plik_in_if import plik_pkg::*; ();
    logic     valid;
    logic     ready;
    plik_in_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface plik_out_if import plik_pkg::*; ();
    logic      valid;
    logic      ready;
    plik_out_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/planar_three_link_ik_solver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_three_link_ik_solver
// Jacobian pseudo-inverse inverse kinematics for a planar arm of three
// equal links, with a controller stepping a shared fixed-point datapath.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out; one item is solved at a time.
// An iteration runs the serial CORDIC for each joint and then the restoring
// divider twice, once for each component of the Gram-matrix solve.
// The result sits in an output register, so the next item is accepted meanwhile.
// Asynchronous active-low reset clears control state and loads register defaults.
module planar_three_link_ik_solver import plik_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    plik_in_if.sink     request,
    plik_out_if.source  result,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    plik_cfg_t    cfg;
    plik_cmd_t    cmd;
    plik_status_t status;
    plik_out_t    res_data;

    plik_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    plik_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (request.valid),
        .in_ready        (request.ready),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .iteration_limit (cfg.iteration_limit),
        .status          (status),
        .cmd             (cmd)
    );

    plik_datapath u_dp
    (
        .clk     (clk),
        .cmd     (cmd),
        .cfg     (cfg),
        .in_data (request.payload),
        .status  (status),
        .result  (res_data)
    );

    assign result.payload = res_data;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> !request.ready)
        else $error("solver still ready after taking a transaction");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.payload.solve_status == ST_CONVERGED ||
                          result.payload.solve_status == ST_LIMIT ||
                          result.payload.solve_status == ST_SINGULAR))
        else $error("undefined solve status on result");

endmodule

[rtl/plik_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plik_cfg
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
module plik_cfg import plik_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output plik_cfg_t   cfg
);

    plik_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_gain       <= 16'd655;
            cfg_reg.error_tolerance <= 13'd8;
            cfg_reg.iteration_limit <= 10'd200;
            cfg_reg.link_length     <= 14'd8192;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STEP_GAIN:       cfg_reg.step_gain       <= cfg_data;
                REG_ERROR_TOLERANCE: cfg_reg.error_tolerance <= cfg_data[12:0];
                REG_ITERATION_LIMIT: cfg_reg.iteration_limit <= cfg_data[9:0];
                REG_LINK_LENGTH:     cfg_reg.link_length     <= cfg_data[13:0];
                default:             ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/plik_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plik_datapath
// CORDIC, error, Jacobian, Gram matrix, restoring divider and angle update
// registers, stepped one operation per cycle by the controller.
// ----------------------------------------------------------------------------
module plik_datapath import plik_pkg::*;
(
    input  logic         clk,
    input  plik_cmd_t    cmd,
    input  plik_cfg_t    cfg,
    input  plik_in_t     in_data,
    output plik_status_t status,
    output plik_out_t    result
);

    logic signed [15:0]  q_reg [JOINTS];
    logic signed [15:0]  gx_reg, gy_reg;
    logic signed [17:0]  acc_reg;
    logic signed [ZW-1:0] z_reg;
    logic signed [XW-1:0] x_reg, y_reg;
    logic                flip_reg;
    logic signed [CW-1:0] sn_reg [JOINTS];
    logic signed [CW-1:0] cs_reg [JOINTS];
    logic signed [SSW-1:0] ssum_reg [JOINTS];
    logic signed [SSW-1:0] csum_reg [JOINTS];
    logic signed [EW-1:0] ex_reg, ey_reg;
    logic signed [ESW-1:0] esq_reg;
    logic [31:0]         tol2_reg;
    logic signed [JW-1:0] j0_reg [JOINTS];
    logic signed [JW-1:0] j1_reg [JOINTS];
    logic signed [AW-1:0] sa_reg, sb_reg, sc_reg;
    logic signed [GW-1:0] aa_reg, bb_reg, cc_reg;
    logic signed [PW-1:0] pa_reg, pb_reg;
    logic signed [DW-1:0] det_reg;
    logic signed [WPW-1:0] pw0_reg, pw1_reg, pw2_reg, pw3_reg;
    logic signed [WW-1:0] w0_reg, w1_reg;
    logic [NW-1:0]       rem_reg;
    logic [DSW-1:0]      ds_reg;
    logic [QW-1:0]       quo_reg;
    logic                satf_reg, neg_reg;
    logic signed [UW-1:0] u0_reg, u1_reg;
    logic signed [SPW-1:0] p0_reg, p1_reg;
    logic signed [SJW-1:0] sj_reg;
    logic signed [GPW-1:0] pg_reg;
    plik_out_t           result_reg;

    logic signed [XW-1:0] dx, dy, xf, yf;
    logic signed [ZW-1:0] at;
    logic signed [14:0]  len_s;
    logic signed [16:0]  gain_s;
    logic signed [LW-1:0] lc0, ls0, lsj, lcj, gxe, gye;
    logic signed [AW-1:0] s00, s01, s11;
    logic signed [WW-1:0] wsel;
    logic signed [NW-1:0] num;
    logic                ge;
    logic [UW-1:0]       mag;
    logic signed [QSW-1:0] dq, qsum;
    logic signed [15:0]  qsat;
    logic [15:0]         tol;

    assign dx     = y_reg >>> cmd.step;
    assign dy     = x_reg >>> cmd.step;
    assign at     = ZW'(signed'({1'b0, atan_lookup(cmd.step)}));
    assign xf     = flip_reg ? -x_reg : x_reg;
    assign yf     = flip_reg ? -y_reg : y_reg;
    assign len_s  = signed'({1'b0, cfg.link_length});
    assign gain_s = signed'({1'b0, cfg.step_gain});
    assign lc0    = len_s * csum_reg[0];
    assign ls0    = len_s * ssum_reg[0];
    assign lsj    = len_s * ssum_reg[cmd.joint];
    assign lcj    = len_s * csum_reg[cmd.joint];
    assign gxe    = LW'(gx_reg) <<< 16;
    assign gye    = LW'(gy_reg) <<< 16;
    assign s00    = AW'(j0_reg[cmd.joint]) * AW'(j0_reg[cmd.joint]);
    assign s01    = AW'(j0_reg[cmd.joint]) * AW'(j1_reg[cmd.joint]);
    assign s11    = AW'(j1_reg[cmd.joint]) * AW'(j1_reg[cmd.joint]);
    assign wsel   = cmd.sel ? w1_reg : w0_reg;
    assign num    = NW'(wsel) <<< 16;
    assign ge     = DSW'(rem_reg) >= ds_reg;
    assign mag    = (satf_reg || (quo_reg > 32'h8000_0000)) ? 33'h0_8000_0000
                                                           : {1'b0, quo_reg};
    assign dq     = QSW'((pg_reg + 57'sd262144) >>> 19);
    assign qsum   = QSW'(q_reg[cmd.joint]) + dq;
    assign tol    = {cfg.error_tolerance, 3'b000};

    always_comb
    begin
        if (qsum > 39'sd32767)
            qsat = 16'sh7fff;
        else if (qsum < -39'sd32768)
            qsat = -16'sh8000;
        else
            qsat = 16'(qsum);
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                q_reg[0] <= in_data.start_angle_0;
                q_reg[1] <= in_data.start_angle_1;
                q_reg[2] <= in_data.start_angle_2;
                gx_reg   <= in_data.goal_x;
                gy_reg   <= in_data.goal_y;
            end
            OP_ACC:
                acc_reg <= ((cmd.joint == 2'd0) ? 18'sd0 : acc_reg) + 18'(q_reg[cmd.joint]);
            OP_ZLOAD:
            begin
                z_reg    <= ZW'(acc_reg) <<< 11;
                x_reg    <= CORDIC_START;
                y_reg    <= '0;
                flip_reg <= 1'b0;
            end
            OP_WRAP:
            begin
                if (z_reg > ANG_PI)
                    z_reg <= z_reg - ANG_TWO_PI;
                else if (z_reg < NEG_PI)
                    z_reg <= z_reg + ANG_TWO_PI;
            end
            OP_FOLD:
            begin
                if (z_reg > ANG_HALF_PI)
                begin
                    z_reg    <= z_reg - ANG_PI;
                    flip_reg <= 1'b1;
                end
                else if (z_reg < NEG_HALF_PI)
                begin
                    z_reg    <= z_reg + ANG_PI;
                    flip_reg <= 1'b1;
                end
            end
            OP_ROT:
            begin
                if (!z_reg[ZW-1])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
            end
            OP_SC:
            begin
                cs_reg[cmd.joint] <= CW'((xf + 33'sd8192) >>> 14);
                sn_reg[cmd.joint] <= CW'((yf + 33'sd8192) >>> 14);
            end
            OP_SUMS:
            begin
                ssum_reg[2] <= SSW'(sn_reg[2]);
                csum_reg[2] <= SSW'(cs_reg[2]);
                ssum_reg[1] <= SSW'(sn_reg[1]) + SSW'(sn_reg[2]);
                csum_reg[1] <= SSW'(cs_reg[1]) + SSW'(cs_reg[2]);
                ssum_reg[0] <= SSW'(sn_reg[0]) + SSW'(sn_reg[1]) + SSW'(sn_reg[2]);
                csum_reg[0] <= SSW'(cs_reg[0]) + SSW'(cs_reg[1]) + SSW'(cs_reg[2]);
            end
            OP_ERR:
            begin
                ex_reg <= EW'((gxe - lc0 + 35'sd4096) >>> 13);
                ey_reg <= EW'((gye - ls0 + 35'sd4096) >>> 13);
            end
            OP_ESQ:
            begin
                esq_reg  <= ESW'(ex_reg) * ESW'(ex_reg) + ESW'(ey_reg) * ESW'(ey_reg);
                tol2_reg <= 32'(tol) * 32'(tol);
            end
            OP_JAC:
            begin
                j0_reg[cmd.joint] <= JW'((35'sd4096 - lsj) >>> 13);
                j1_reg[cmd.joint] <= JW'((lcj + 35'sd4096) >>> 13);
            end
            OP_GRAM:
            begin
                sa_reg <= ((cmd.joint == 2'd0) ? 44'sd0 : sa_reg) + s00;
                sb_reg <= ((cmd.joint == 2'd0) ? 44'sd0 : sb_reg) + s01;
                sc_reg <= ((cmd.joint == 2'd0) ? 44'sd0 : sc_reg) + s11;
            end
            OP_ABC:
            begin
                aa_reg <= GW'((sa_reg + 44'sd32768) >>> 16);
                bb_reg <= GW'((sb_reg + 44'sd32768) >>> 16);
                cc_reg <= GW'((sc_reg + 44'sd32768) >>> 16);
            end
            OP_DET:
            begin
                pa_reg <= PW'(aa_reg) * PW'(cc_reg);
                pb_reg <= PW'(bb_reg) * PW'(bb_reg);
            end
            OP_DET2:
                det_reg <= DW'(pa_reg) - DW'(pb_reg);
            OP_W:
            begin
                pw0_reg <= WPW'(cc_reg) * WPW'(ex_reg);
                pw1_reg <= WPW'(bb_reg) * WPW'(ey_reg);
                pw2_reg <= WPW'(aa_reg) * WPW'(ey_reg);
                pw3_reg <= WPW'(bb_reg) * WPW'(ex_reg);
            end
            OP_W2:
            begin
                w0_reg <= WW'(pw0_reg) - WW'(pw1_reg);
                w1_reg <= WW'(pw2_reg) - WW'(pw3_reg);
            end
            OP_DIVI:
            begin
                neg_reg  <= num[NW-1];
                rem_reg  <= num[NW-1] ? unsigned'(-num) : unsigned'(num);
                ds_reg   <= {det_reg[PW-1:0], 32'b0};
                quo_reg  <= '0;
                satf_reg <= 1'b0;
            end
            OP_DIVS:
            begin
                if (cmd.first)
                    satf_reg <= ge;
                else if (ge)
                begin
                    rem_reg           <= rem_reg - ds_reg[NW-1:0];
                    quo_reg[cmd.step] <= 1'b1;
                end
                ds_reg <= ds_reg >> 1;
            end
            OP_DIVE:
            begin
                if (cmd.sel)
                    u1_reg <= neg_reg ? -signed'(mag) : signed'(mag);
                else
                    u0_reg <= neg_reg ? -signed'(mag) : signed'(mag);
            end
            OP_ST1:
            begin
                p0_reg <= SPW'(j0_reg[cmd.joint]) * SPW'(u0_reg);
                p1_reg <= SPW'(j1_reg[cmd.joint]) * SPW'(u1_reg);
            end
            OP_ST2:
                sj_reg <= SJW'((55'(p0_reg) + 55'(p1_reg) + 55'sd32768) >>> 16);
            OP_ST3:
                pg_reg <= GPW'(gain_s) * GPW'(sj_reg);
            OP_ST4:
                q_reg[cmd.joint] <= qsat;
            OP_PUB:
            begin
                result_reg.joint_angle_0   <= q_reg[0];
                result_reg.joint_angle_1   <= q_reg[1];
                result_reg.joint_angle_2   <= q_reg[2];
                result_reg.solve_status    <= cmd.code;
                result_reg.iterations_used <= cmd.iters;
            end
            default: ;
        endcase
    end

    assign status.z_wide    = (z_reg > ANG_PI) || (z_reg < NEG_PI);
    assign status.converged = esq_reg < ESW'(signed'({1'b0, tol2_reg}));
    assign status.singular  = det_reg[DW-1] || (det_reg == '0);
    assign result           = result_reg;

endmodule

[rtl/plik_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plik_ctrl
// Sequencer for the solver: joint and CORDIC step loops, the divider bit
// loop, the stop tests and the result handshake.
// ----------------------------------------------------------------------------
module plik_ctrl import plik_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  logic [9:0]   iteration_limit,
    input  plik_status_t status,
    output plik_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_ACC, S_ZLOAD, S_WRAP, S_ROT, S_SC, S_SUMS, S_ERR,
        S_ESQ, S_CONV, S_JAC, S_GRAM, S_ABC, S_DET, S_DET2, S_SING, S_W, S_W2,
        S_DIVI, S_DIVS, S_DIVE, S_ST1, S_ST2, S_ST3, S_ST4, S_PUB
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] joint_reg, joint_next;
    logic [4:0] step_reg, step_next;
    logic       sel_reg, sel_next;
    logic       first_reg, first_next;
    logic [9:0] iter_reg, iter_next;
    logic [1:0] code_reg, code_next;
    logic       out_valid_reg, out_valid_next;
    plik_op_t   op;

    always_comb
    begin
        state_next     = state_reg;
        joint_next     = joint_reg;
        step_next      = step_reg;
        sel_next       = sel_reg;
        first_next     = first_reg;
        iter_next      = iter_reg;
        code_next      = code_reg;
        out_valid_next = out_valid_reg && !out_ready;
        op             = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    iter_next  = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                joint_next = 2'd0;
                if (iter_reg < iteration_limit)
                    state_next = S_ACC;
                else
                begin
                    code_next  = ST_LIMIT;
                    state_next = S_PUB;
                end
            end
            S_ACC:
            begin
                op         = OP_ACC;
                state_next = S_ZLOAD;
            end
            S_ZLOAD:
            begin
                op         = OP_ZLOAD;
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                if (status.z_wide)
                    op = OP_WRAP;
                else
                begin
                    op         = OP_FOLD;
                    step_next  = '0;
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                op = OP_ROT;
                if (step_reg == 5'(CORDIC_STEPS - 1))
                    state_next = S_SC;
                else
                    step_next = step_reg + 5'd1;
            end
            S_SC:
            begin
                op = OP_SC;
                if (joint_reg == 2'(JOINTS - 1))
                    state_next = S_SUMS;
                else
                begin
                    joint_next = joint_reg + 2'd1;
                    state_next = S_ACC;
                end
            end
            S_SUMS:
            begin
                op         = OP_SUMS;
                state_next = S_ERR;
            end
            S_ERR:
            begin
                op         = OP_ERR;
                state_next = S_ESQ;
            end
            S_ESQ:
            begin
                op         = OP_ESQ;
                state_next = S_CONV;
            end
            S_CONV:
            begin
                joint_next = 2'd0;
                if (status.converged)
                begin
                    code_next  = ST_CONVERGED;
                    state_next = S_PUB;
                end
                else
                    state_next = S_JAC;
            end
            S_JAC:
            begin
                op = OP_JAC;
                if (joint_reg == 2'(JOINTS - 1))
                begin
                    joint_next = 2'd0;
                    state_next = S_GRAM;
                end
                else
                    joint_next = joint_reg + 2'd1;
            end
            S_GRAM:
            begin
                op = OP_GRAM;
                if (joint_reg == 2'(JOINTS - 1))
                    state_next = S_ABC;
                else
                    joint_next = joint_reg + 2'd1;
            end
            S_ABC:
            begin
                op         = OP_ABC;
                state_next = S_DET;
            end
            S_DET:
            begin
                op         = OP_DET;
                state_next = S_DET2;
            end
            S_DET2:
            begin
                op         = OP_DET2;
                state_next = S_SING;
            end
            S_SING:
            begin
                if (status.singular)
                begin
                    code_next  = ST_SINGULAR;
                    state_next = S_PUB;
                end
                else
                    state_next = S_W;
            end
            S_W:
            begin
                op         = OP_W;
                state_next = S_W2;
            end
            S_W2:
            begin
                op         = OP_W2;
                sel_next   = 1'b0;
                state_next = S_DIVI;
            end
            S_DIVI:
            begin
                op         = OP_DIVI;
                first_next = 1'b1;
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                op = OP_DIVS;
                if (first_reg)
                begin
                    first_next = 1'b0;
                    step_next  = 5'd31;
                end
                else if (step_reg == 5'd0)
                    state_next = S_DIVE;
                else
                    step_next = step_reg - 5'd1;
            end
            S_DIVE:
            begin
                op = OP_DIVE;
                if (!sel_reg)
                begin
                    sel_next   = 1'b1;
                    state_next = S_DIVI;
                end
                else
                begin
                    joint_next = 2'd0;
                    state_next = S_ST1;
                end
            end
            S_ST1:
            begin
                op         = OP_ST1;
                state_next = S_ST2;
            end
            S_ST2:
            begin
                op         = OP_ST2;
                state_next = S_ST3;
            end
            S_ST3:
            begin
                op         = OP_ST3;
                state_next = S_ST4;
            end
            S_ST4:
            begin
                op = OP_ST4;
                if (joint_reg == 2'(JOINTS - 1))
                begin
                    iter_next  = iter_reg + 10'd1;
                    state_next = S_CHECK;
                end
                else
                begin
                    joint_next = joint_reg + 2'd1;
                    state_next = S_ST1;
                end
            end
            S_PUB:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    op             = OP_PUB;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            joint_reg     <= '0;
            step_reg      <= '0;
            sel_reg       <= 1'b0;
            first_reg     <= 1'b0;
            iter_reg      <= '0;
            code_reg      <= ST_CONVERGED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            joint_reg     <= joint_next;
            step_reg      <= step_next;
            sel_reg       <= sel_next;
            first_reg     <= first_next;
            iter_reg      <= iter_next;
            code_reg      <= code_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    assign cmd.op    = op;
    assign cmd.joint = joint_reg;
    assign cmd.step  = step_reg;
    assign cmd.sel   = sel_reg;
    assign cmd.first = first_reg;
    assign cmd.code  = code_reg;
    assign cmd.iters = iter_reg;

endmodule

[tb/sv/tb_planar_three_link_ik_solver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_planar_three_link_ik_solver
// Self-checking testbench for the three-link inverse kinematics solver.
// A clocked driver feeds request transactions from a queue, a clocked monitor
// predicts each solution with a bit-exact fixed-point model of the solver and
// compares every result transaction field by field. Phases change the
// configuration between drained runs and vary sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_planar_three_link_ik_solver;
    import plik_pkg::*;

    localparam int CORDIC_ITERS = 16;
    localparam int WATCHDOG_LIMIT = 500000;
    localparam longint ROT_HALF_PI = 26353589;
    localparam longint ROT_PI = 52707179;
    localparam longint ROT_TWO_PI = 105414357;
    localparam longint ROT_START = 652032874;
    localparam longint STEP_LIMIT = 64'sd1 <<< 31;
    localparam longint ARCTAN [0:15] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    plik_in_if  req_if ();
    plik_out_if res_if ();

    planar_three_link_ik_solver dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if),
        .result   (res_if),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    plik_in_t  pending_requests [$];
    plik_out_t expected_solutions [$];
    int        send_idle_pct;
    int        recv_stall_pct;
    int        error_count;
    int        quiet_cycles;

    longint gain_q;
    longint tol_q;
    longint limit_q;
    longint link_q;

    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint clamp_step(input longint v);
        if (v > STEP_LIMIT)
            return STEP_LIMIT;
        if (v < -STEP_LIMIT)
            return -STEP_LIMIT;
        return v;
    endfunction

    task automatic rotate_angle(input longint ang, output longint sn, output longint cs);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z = ang * 2048;
        x = ROT_START;
        y = 0;
        flip = 0;
        while (z > ROT_PI)
            z -= ROT_TWO_PI;
        while (z < -ROT_PI)
            z += ROT_TWO_PI;
        if (z > ROT_HALF_PI)
        begin
            z -= ROT_PI;
            flip = 1;
        end
        else if (z < -ROT_HALF_PI)
        begin
            z += ROT_PI;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= ARCTAN[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += ARCTAN[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cs = round_shift(x, 14);
        sn = round_shift(y, 14);
    endtask

    task automatic solve_arm(input plik_in_t rq, output plik_out_t sol);
        longint q [3];
        longint sn [3];
        longint cs [3];
        longint ssum [3];
        longint csum [3];
        longint j0 [3];
        longint j1 [3];
        longint gx, gy, tol2, acc, rs, rc, ex, ey;
        longint sa, sb, sc, aa, bb, cc, det, w0, w1, u0, u1, sj, dq;
        int     iters;
        logic [1:0] status;
        gx = longint'(rq.goal_x) * 65536;
        gy = longint'(rq.goal_y) * 65536;
        tol2 = (tol_q * 8) * (tol_q * 8);
        q[0] = rq.start_angle_0;
        q[1] = rq.start_angle_1;
        q[2] = rq.start_angle_2;
        iters = 0;
        status = ST_LIMIT;
        while (iters < limit_q)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
            begin
                acc += q[j];
                rotate_angle(acc, sn[j], cs[j]);
            end
            rs = 0;
            rc = 0;
            for (int j = 2; j >= 0; j--)
            begin
                rs += sn[j];
                rc += cs[j];
                ssum[j] = rs;
                csum[j] = rc;
            end
            ex = round_shift(gx - link_q * csum[0], 13);
            ey = round_shift(gy - link_q * ssum[0], 13);
            if (ex * ex + ey * ey < tol2)
            begin
                status = ST_CONVERGED;
                break;
            end
            sa = 0;
            sb = 0;
            sc = 0;
            for (int j = 0; j < 3; j++)
            begin
                j0[j] = round_shift(-link_q * ssum[j], 13);
                j1[j] = round_shift(link_q * csum[j], 13);
                sa += j0[j] * j0[j];
                sb += j0[j] * j1[j];
                sc += j1[j] * j1[j];
            end
            aa = round_shift(sa, 16);
            bb = round_shift(sb, 16);
            cc = round_shift(sc, 16);
            det = aa * cc - bb * bb;
            if (det <= 0)
            begin
                status = ST_SINGULAR;
                break;
            end
            w0 = cc * ex - bb * ey;
            w1 = aa * ey - bb * ex;
            u0 = clamp_step((w0 * 65536) / det);
            u1 = clamp_step((w1 * 65536) / det);
            for (int j = 0; j < 3; j++)
            begin
                sj = round_shift(j0[j] * u0 + j1[j] * u1, 16);
                dq = round_shift(gain_q * sj, 19);
                q[j] = clamp16(q[j] + dq);
            end
            iters++;
        end
        sol.joint_angle_0 = q[0][15:0];
        sol.joint_angle_1 = q[1][15:0];
        sol.joint_angle_2 = q[2][15:0];
        sol.solve_status = status;
        sol.iterations_used = iters[9:0];
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            req_if.payload <= '0;
        end
        else if (!req_if.valid || req_if.ready)
        begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req_if.payload <= pending_requests.pop_front();
                req_if.valid <= 1'b1;
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        plik_out_t sol;
        plik_out_t got;
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
            begin
                solve_arm(req_if.payload, sol);
                expected_solutions.push_back(sol);
            end
            if (res_if.valid && res_if.ready)
            begin
                got = res_if.payload;
                if (expected_solutions.size() == 0)
                    report_mismatch("result transaction with no request pending");
                else
                begin
                    sol = expected_solutions.pop_front();
                    if (got.joint_angle_0 !== sol.joint_angle_0)
                        report_mismatch($sformatf("joint_angle_0 %0d, want %0d",
                            got.joint_angle_0, sol.joint_angle_0));
                    if (got.joint_angle_1 !== sol.joint_angle_1)
                        report_mismatch($sformatf("joint_angle_1 %0d, want %0d",
                            got.joint_angle_1, sol.joint_angle_1));
                    if (got.joint_angle_2 !== sol.joint_angle_2)
                        report_mismatch($sformatf("joint_angle_2 %0d, want %0d",
                            got.joint_angle_2, sol.joint_angle_2));
                    if (got.solve_status !== sol.solve_status)
                        report_mismatch($sformatf("solve_status %0d, want %0d",
                            got.solve_status, sol.solve_status));
                    if (got.iterations_used !== sol.iterations_used)
                        report_mismatch($sformatf("iterations_used %0d, want %0d",
                            got.iterations_used, sol.iterations_used));
                end
            end
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_STEP_GAIN:       gain_q = longint'(value);
            REG_ERROR_TOLERANCE: tol_q = longint'(value[12:0]);
            REG_ITERATION_LIMIT: limit_q = longint'(value[9:0]);
            REG_LINK_LENGTH:     link_q = longint'(value[13:0]);
            default: ;
        endcase
    endtask

    task automatic configure(input int gain, input int tol, input int lim, input int len);
        write_reg(REG_STEP_GAIN, 16'(gain));
        write_reg(REG_ERROR_TOLERANCE, 16'(tol));
        write_reg(REG_ITERATION_LIMIT, 16'(lim));
        write_reg(REG_LINK_LENGTH, 16'(len));
    endtask

    task automatic queue_request(input int a0, input int a1, input int a2,
                                 input int gx, input int gy);
        plik_in_t rq;
        rq.start_angle_0 = 16'(a0);
        rq.start_angle_1 = 16'(a1);
        rq.start_angle_2 = 16'(a2);
        rq.goal_x = 16'(gx);
        rq.goal_y = 16'(gy);
        pending_requests.push_back(rq);
    endtask

    task automatic queue_random(input int count);
        int reach;
        for (int n = 0; n < count; n++)
        begin
            reach = int'(3 * link_q);
            if (reach > 32767)
                reach = 32767;
            if ($urandom_range(3) == 0)
                queue_request($urandom, $urandom, $urandom, $urandom, $urandom);
            else
                queue_request($urandom_range(51472) - 25736,
                              $urandom_range(51472) - 25736,
                              $urandom_range(51472) - 25736,
                              $urandom_range(2 * reach) - reach,
                              $urandom_range(2 * reach) - reach);
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_requests.size() > 0 || req_if.valid || expected_solutions.size() > 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        quiet_cycles = 0;
        gain_q = 655;
        tol_q = 8;
        limit_q = 200;
        link_q = 8192;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        queue_request(0, 0, 0, 16384, 8192);
        queue_request(4000, -2000, 1000, -8192, 12000);
        drain();

        configure(65535, 0, 4, 16383);
        queue_request(0, 0, 0, 0, 0);
        queue_request(32767, 32767, 32767, 32767, 32767);
        queue_request(-32768, -32768, -32768, -32768, -32768);
        queue_request(32767, -32768, 0, -32768, 32767);
        queue_request(25736, -25736, 12868, 0, 24576);
        queue_request(-12868, 12868, 25737, 24576, -8192);
        queue_request(12869, 12867, -12869, 1, -1);
        queue_request(0, 0, 0, 49152 - 32768, 0);
        queue_request(-1, 1, -1, -24000, -24000);
        queue_request(21845, -10922, 5461, 16384, 16384);
        drain();

        configure(0, 8191, 3, 0);
        queue_request(0, 0, 0, 0, 0);
        queue_request(1000, 2000, 3000, 8191, 0);
        queue_request(-5000, 7000, 0, 20000, -20000);
        drain();

        configure(20000, 100, 0, 8192);
        queue_request(1234, -4321, 777, 5000, 5000);
        queue_request(-32768, 32767, -1, -32768, 32767);
        drain();

        write_reg(REG_LINK_LENGTH + 8'd1, 16'hFFFF);
        configure(32768, 200, 1023, 8192);
        queue_request(3000, 3000, 3000, 12000, 10000);
        queue_request(-6000, 8000, -2000, 16000, -4000);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            configure($urandom, $urandom_range(300), $urandom_range(12, 1),
                      $urandom_range(16383));
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            queue_random(20);
            drain();
        end

        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
